/* src/b64d_pkg.sv */
`timescale 1ns / 1ps
// Package for the base64 decoder: status codes, character marks, the group
// record passed from front to back, and the character-to-sextet mapping.
package b64d_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_PAD      = 2'd2;
    localparam logic [1:0] ST_LENGTH   = 2'd3;

    localparam logic [6:0] PAD_MARK = 7'd64;
    localparam logic [7:0] BAD_MARK = 8'hFF;

    // one record per closed group or per message-ending status
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] leaves first
        logic [1:0]      cnt;     // number of data bytes, 0 for a status item
        logic            eom;
        logic [1:0]      status;
    } t_rec;

    // map a character code to 0..63, PAD_MARK for '=', BAD_MARK otherwise
    function automatic logic [7:0] sextet_of(input logic [7:0] ch);
        logic [7:0] res;
        res = BAD_MARK;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            res = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            res = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            res = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h2B) begin
            res = 8'd62;
        end else if (ch == 8'h2F) begin
            res = 8'd63;
        end else if (ch == 8'h3D) begin
            res = {1'b0, PAD_MARK};
        end
        return res;
    endfunction

endpackage

/* src/base64_decoder_with_validation_core.sv */
`timescale 1ns / 1ps
// Top level of the streaming base64 decoder with validation.
// Instantiates b64d_front, b64d_fifo and b64d_back; depends on b64d_pkg.
//
// Decodes one message of standard base64 text (padding required, no
// whitespace), one character per item, with i_last_char on the final one.
// Every item out is either a decoded byte (o_has_byte high, o_status zero)
// or, after an error, a single status-only item ending the message:
// status 1 invalid character, 2 misplaced padding, 3 length not a multiple
// of four. Bytes decoded before an error have already gone out; drop the
// message when a non-zero status arrives. o_end_of_message marks the last
// item of every message. Rate: one character is taken every cycle while
// the record queue has room; the output stage gives one item per cycle while
// the receiver is ready, so three bytes per four characters keeps up with a
// full-rate input stream. Decoded bytes pass through the queue register and
// then the output register. Stalls on the output side back up into the
// QUEUE_DEPTH-entry record queue before o_in_ready drops.
module base64_decoder_with_validation_core
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character side
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    // decoded side
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_message,
    output logic [1:0] o_status
);
    logic accept;
    logic push, pop, full, empty;
    t_rec front_rec, head_rec;

    // take a character whenever the queue can hold whatever it produces
    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_byte (i_char_byte),
        .i_last_char (i_last_char),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    b64d_fifo #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rec),
        .i_pop   (pop),
        .o_data  (head_rec),
        .o_full  (full),
        .o_empty (empty)
    );

    b64d_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec            (head_rec),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_has_byte       (o_has_byte),
        .o_end_of_message (o_end_of_message),
        .o_status         (o_status)
    );
endmodule

/* src/b64d_fifo.sv */
`timescale 1ns / 1ps
// Small register queue carrying group records from front to back.
// Generic in width and depth; no package dependency.
module b64d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

/* src/b64d_front.sv */
`timescale 1ns / 1ps
// Front part of the base64 decoder: classifies characters, checks padding
// and length, assembles groups into records. Depends on b64d_pkg.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    output logic       o_push,
    output t_rec       o_rec
);
    logic [6:0] r_held [3];
    logic [6:0] n_held [3];
    logic [1:0] r_pos, n_pos;
    logic [1:0] r_err, n_err;

    logic [7:0] v8;
    logic [6:0] v;
    logic       bad;
    logic       grp_done;
    logic [5:0] a, b, c6, d6;
    logic [2:0][7:0] grp_bytes;
    logic [1:0] grp_cnt;

    always_comb begin
        v8  = sextet_of(i_char_byte);
        v   = v8[6:0];
        bad = (v8 == BAD_MARK);
        a   = r_held[0][5:0];
        b   = r_held[1][5:0];
        c6  = r_held[2][5:0];
        d6  = v[5:0];
        grp_bytes[0] = {a, b[5:4]};
        grp_bytes[1] = {b[3:0], c6[5:2]};
        grp_bytes[2] = {c6[1:0], d6};
        if (r_held[2] == PAD_MARK) begin
            grp_cnt = 2'd1;
        end else if (v == PAD_MARK) begin
            grp_cnt = 2'd2;
        end else begin
            grp_cnt = 2'd3;
        end

        n_held   = r_held;
        n_pos    = r_pos;
        n_err    = r_err;
        grp_done = 1'b0;
        o_push   = 1'b0;
        o_rec    = '0;

        if (r_err == ST_OK) begin
            if (bad) begin
                n_err = ST_BAD_CHAR;
            end else if (r_pos < 2'd2 && v == PAD_MARK) begin
                n_err = ST_PAD;
            end else if (r_pos != 2'd3) begin
                n_held[r_pos] = v;
                n_pos = r_pos + 2'd1;
            end else if (r_held[2] == PAD_MARK && v != PAD_MARK) begin
                n_err = ST_PAD;
            end else if ((r_held[2] == PAD_MARK || v == PAD_MARK) && !i_last_char) begin
                n_err = ST_PAD;
            end else begin
                grp_done = 1'b1;
                n_pos    = 2'd0;
            end
        end

        if (n_err == ST_OK && i_last_char && n_pos != 2'd0) begin
            n_err = ST_LENGTH;
        end

        if (n_err == ST_OK && grp_done) begin
            o_push       = i_accept;
            o_rec.bytes  = grp_bytes;
            o_rec.cnt    = grp_cnt;
            o_rec.eom    = i_last_char;
            o_rec.status = ST_OK;
        end
        if (i_last_char && n_err != ST_OK) begin
            o_push       = i_accept;
            o_rec        = '0;
            o_rec.eom    = 1'b1;
            o_rec.status = n_err;
        end

        if (i_last_char) begin
            n_held[0] = '0;
            n_held[1] = '0;
            n_held[2] = '0;
            n_pos     = '0;
            n_err     = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0] <= '0;
            r_held[1] <= '0;
            r_held[2] <= '0;
            r_pos     <= '0;
            r_err     <= ST_OK;
        end else if (i_accept) begin
            r_held <= n_held;
            r_pos  <= n_pos;
            r_err  <= n_err;
        end
    end
endmodule

/* src/b64d_back.sv */
`timescale 1ns / 1ps
// Back part of the base64 decoder: walks the head record byte by byte into
// a registered output stage. Depends on b64d_pkg.
module b64d_back
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rec       i_rec,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_end_of_message,
    output logic [1:0] o_status
);
    logic [1:0] r_idx;
    logic [1:0] items_m1;
    logic       out_free, emit, last_item;

    assign items_m1  = (i_rec.cnt == 2'd0) ? 2'd0 : i_rec.cnt - 2'd1;
    assign out_free  = !o_valid || i_ready;
    assign emit      = !i_empty && out_free;
    assign last_item = (r_idx == items_m1);
    assign o_pop     = emit && last_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx   <= last_item ? 2'd0 : r_idx + 2'd1;
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload: hold until the next emit
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out_byte       <= i_rec.bytes[r_idx];
            o_has_byte       <= (i_rec.cnt != 2'd0);
            o_end_of_message <= i_rec.eom && last_item;
            o_status         <= i_rec.status;
        end
    end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for base64_decoder_with_validation_core: feeds base64 messages
// one character per item and checks every decoded item against a local decoder.
// Depends on b64d_pkg for the status codes and the pad and bad-character marks.
module tb_top;
    import b64d_pkg::*;

    localparam logic [7:0] CH_PAD      = 8'h3D;   // '='
    localparam int         IDLE_LIMIT  = 2000;    // cycles with no item moving on either side
    localparam int         LONG_HOLD   = 300;     // receiver hold-off in the pressure test
    localparam int         PRINT_LIMIT = 40;
    localparam string      SEXTET_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // receiver stall styles
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_message;
        logic [1:0] status;
    } t_dec_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_byte = 8'h00;
    logic       i_last_char = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_end_of_message;
    logic [1:0] o_status;

    // decoder state mirrored by the bench
    logic [6:0] held_sextet [3];
    logic [1:0] group_pos;
    logic [1:0] first_error;
    t_dec_item  decoded_q [$];
    t_dec_item  head_item;

    int err_count   = 0;
    int chars_sent  = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;
    int rx_mode     = RX_RANDOM;
    int hold_cycles = 0;
    int rx_phase    = 0;
    int idle_cycles = 0;

    base64_decoder_with_validation_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_char_byte      (i_char_byte),
        .i_last_char      (i_last_char),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_has_byte       (o_has_byte),
        .o_end_of_message (o_end_of_message),
        .o_status         (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Local decoder
    // ------------------------------------------------------------------

    // Map a character to 0..63, the pad mark for '=', or the bad mark.
    function automatic logic [7:0] char_to_sextet(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return ch - "A";
        if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
        if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
        if (ch == "+") return 8'd62;
        if (ch == "/") return 8'd63;
        if (ch == CH_PAD) return {1'b0, PAD_MARK};
        return BAD_MARK;
    endfunction

    function automatic void clear_decoder();
        held_sextet = '{default: 7'd0};
        group_pos   = 2'd0;
        first_error = ST_OK;
    endfunction

    // Advance the local decoder by one accepted character and queue the
    // items it must produce.
    function automatic void predict_decode(input logic [7:0] ch, input logic last);
        logic [7:0] v;
        logic [6:0] a, b, c, d;
        logic [7:0] dec_bytes [3];
        int         nbytes;
        nbytes = 0;
        if (first_error == ST_OK) begin
            v = char_to_sextet(ch);
            if (v == BAD_MARK) begin
                first_error = ST_BAD_CHAR;
            end else if (group_pos < 2 && v[6:0] == PAD_MARK) begin
                first_error = ST_PAD;
            end else if (group_pos < 3) begin
                held_sextet[group_pos] = v[6:0];
                group_pos = group_pos + 2'd1;
            end else begin
                a = held_sextet[0];
                b = held_sextet[1];
                c = held_sextet[2];
                d = v[6:0];
                if (c == PAD_MARK && d != PAD_MARK) begin
                    first_error = ST_PAD;
                end else if ((c == PAD_MARK || d == PAD_MARK) && !last) begin
                    // padding is only allowed in the final group
                    first_error = ST_PAD;
                end else begin
                    dec_bytes[0] = {a[5:0], b[5:4]};
                    nbytes = 1;
                    if (c != PAD_MARK) begin
                        dec_bytes[1] = {b[3:0], c[5:2]};
                        nbytes = 2;
                        if (d != PAD_MARK) begin
                            dec_bytes[2] = {c[1:0], d[5:0]};
                            nbytes = 3;
                        end
                    end
                    group_pos = 2'd0;
                end
            end
        end
        if (first_error == ST_OK && last && group_pos != 2'd0)
            first_error = ST_LENGTH;
        if (first_error == ST_OK) begin
            for (int i = 0; i < nbytes; i++)
                decoded_q.push_back('{dec_bytes[i], 1'b1, last && (i == nbytes - 1), ST_OK});
        end
        if (last && first_error != ST_OK)
            decoded_q.push_back('{8'h00, 1'b0, 1'b1, first_error});
        if (last)
            clear_decoder();
    endfunction

    // Encode raw bytes as well-formed padded base64 text.
    function automatic void encode_b64(input logic [7:0] raw [$], output logic [7:0] txt [$]);
        logic [23:0] w;
        int          left;
        txt = {};
        for (int i = 0; i < raw.size(); i += 3) begin
            left = raw.size() - i;
            w = {raw[i], (left > 1) ? raw[i + 1] : 8'h00, (left > 2) ? raw[i + 2] : 8'h00};
            txt.push_back(SEXTET_CHARS[w[23:18]]);
            txt.push_back(SEXTET_CHARS[w[17:12]]);
            txt.push_back((left > 1) ? SEXTET_CHARS[w[11:6]] : CH_PAD);
            txt.push_back((left > 2) ? SEXTET_CHARS[w[5:0]] : CH_PAD);
        end
    endfunction

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------

    // Offer one character and hold it until taken. When gaps_on is set, gaps come
    // between bursts of random length; each call starts and ends on a rising edge.
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_decode(ch, last);
        chars_sent++;
    endtask

    task automatic send_message(input logic [7:0] msg [$]);
        for (int i = 0; i < msg.size(); i++)
            send_char(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] msg [$];
        msg = {};
        for (int i = 0; i < s.len(); i++)
            msg.push_back(s[i]);
        send_message(msg);
    endtask

    // ------------------------------------------------------------------
    // Decoded side: stall process, checker, watchdog
    // ------------------------------------------------------------------

    // A pending hold-off wins over the current stall style.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                rx_phase = (rx_phase + 1) % 7;
                case (rx_mode)
                    RX_ALWAYS:  i_out_ready <= 1'b1;
                    RX_RANDOM:  i_out_ready <= ($urandom_range(0, 2) != 0);
                    default:    i_out_ready <= (rx_phase > 2);
                endcase
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (err_count < PRINT_LIMIT)
            $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // Compare each item taken from the decoder with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("unexpected item, byte", o_out_byte, 0);
            end else begin
                head_item = decoded_q.pop_front();
                if (o_out_byte !== head_item.out_byte)
                    report_mismatch("out_byte", o_out_byte, head_item.out_byte);
                if (o_has_byte !== head_item.has_byte)
                    report_mismatch("has_byte", o_has_byte, head_item.has_byte);
                if (o_end_of_message !== head_item.end_of_message)
                    report_mismatch("end_of_message", o_end_of_message,
                                    head_item.end_of_message);
                if (o_status !== head_item.status)
                    report_mismatch("status", o_status, head_item.status);
            end
        end
    end

    // Abort when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[base64_decoder_with_validation_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Clean messages: full groups, both pad lengths, all-zero and all-one bits.
    task automatic test_clean_groups();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        send_text("AA//");
        send_text("+/9=");
        send_text("zQ==");
    endtask

    // Messages for every error kind, including errors on the final character
    // and characters ignored after an error.
    task automatic test_format_errors();
        logic [7:0] msg [$];
        send_text("=");       // pad in first place, on the last character
        send_text("A=");      // pad in second place
        send_text("AB=C");    // third-place pad without a fourth
        send_text("AB==A");   // pad in a group that is not the last
        send_text("AB=");     // short final group ending in a pad
        send_text("A");       // short final group
        msg = '{8'h00, 8'hFF};
        send_message(msg);    // invalid character, then one ignored
    endtask

    // Hold the receiver off for a long stretch while characters keep coming,
    // so the record queue fills and the input stalls.
    task automatic test_backpressure();
        logic [7:0] raw [$];
        logic [7:0] msg [$];
        rx_mode     = RX_ALWAYS;
        gaps_on     = 1'b0;
        hold_cycles = LONG_HOLD;
        for (int m = 0; m < 4; m++) begin
            raw = {};
            repeat (6 + m) raw.push_back(8'($urandom_range(0, 255)));
            encode_b64(raw, msg);
            send_message(msg);
        end
    endtask

    // Mostly well-formed messages with random content; the rest altered.
    task automatic test_random_messages();
        logic [7:0] raw [$];
        logic [7:0] msg [$];
        int         target;
        int         nraw;
        int         idx;
        int         k;
        target = chars_sent + 150;
        while (chars_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            nraw = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            raw = {};
            repeat (nraw) raw.push_back(8'($urandom_range(0, 255)));
            encode_b64(raw, msg);
            if ($urandom_range(0, 9) < 3) begin
                idx = $urandom_range(0, msg.size() - 1);
                case ($urandom_range(0, 4))
                    0: msg[idx] = 8'($urandom_range(0, 255));
                    1: msg[idx] = CH_PAD;
                    2: begin
                        k = $urandom_range(1, 3);
                        if (msg.size() > k)
                            msg = msg[0:$-k];
                    end
                    3: repeat ($urandom_range(1, 3))
                        msg.push_back(SEXTET_CHARS[$urandom_range(0, 63)]);
                    default: begin
                        // pure noise
                        msg = {};
                        repeat ($urandom_range(1, 10))
                            msg.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            send_message(msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int drain_cycles;
        clear_decoder();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clean_groups();
        test_format_errors();
        test_backpressure();
        test_random_messages();
        i_in_valid <= 1'b0;

        // let every expected item drain, then allow for the pipeline tail
        rx_mode = RX_RANDOM;
        drain_cycles = 0;
        while (decoded_q.size() != 0 && drain_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch("items never produced", decoded_q.size(), 0);

        if (err_count == 0)
            $display("[base64_decoder_with_validation_core] OK");
        else
            $display("[base64_decoder_with_validation_core] ERROR");
        $finish;
    end

endmodule

/* files.f */
src/b64d_pkg.sv
src/b64d_fifo.sv
src/b64d_front.sv
src/b64d_back.sv
src/base64_decoder_with_validation_core.sv
bench/tb_top.sv
